// ===== hw/rtl/text_stream_line_number_filter_macros.svh =====
// assertion macros for the line number filter checker
`ifndef TEXT_STREAM_LINE_NUMBER_FILTER_MACROS_SVH
`define TEXT_STREAM_LINE_NUMBER_FILTER_MACROS_SVH

// property checked while out of reset
`define TSLNF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked at every edge, reset included
`define TSLNF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/tslnf_pkg.sv =====
package tslnf_pkg;

    // line number formatting
    localparam int NUMBER_DIGITS = 6;
    localparam int BCD_DIGITS    = 6;
    localparam int BCD_W         = 4 * BCD_DIGITS;
    localparam logic [BCD_W-1:0] BCD_MAX = {BCD_DIGITS{4'h9}};

    localparam int SIG_W = $clog2(BCD_DIGITS + 1);
    localparam int PAD_W = $clog2(NUMBER_DIGITS + 1);
    localparam int CNT_W = (PAD_W > SIG_W) ? ((PAD_W > 3) ? PAD_W : 3)
                                           : ((SIG_W > 3) ? SIG_W : 3);

    // configuration port
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_NUMBER_ALL       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NUMBER_NONBLANK  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SHOW_ENDS        = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SQUEEZE_BLANK    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SHOW_TABS        = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SHOW_NONPRINTING = 3'd5;

    // characters
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_UPPER_I = 8'h49;
    localparam logic [7:0] CH_UPPER_M = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_CTRL_END  = 8'h20;
    localparam logic [7:0] CH_META_LO   = 8'h80;
    localparam logic [7:0] CH_META_HI   = 8'h9F;
    localparam logic [7:0] CARET_OFFSET = 8'h40;

    // shape of the byte body
    typedef enum logic [1:0] {
        BODY_PLAIN,
        BODY_CARET,
        BODY_META
    } body_kind_t;

    typedef struct packed {
        logic             number_all;
        logic             number_nonblank;
        logic             show_ends;
        logic             squeeze_blank;
        logic             show_tabs;
        logic             show_nonprinting;
    } cfg_t;

    // everything the emitter needs to produce one item's output
    typedef struct packed {
        logic             num_en;
        logic [BCD_W-1:0] count;
        logic [SIG_W-1:0] sig;
        logic [PAD_W-1:0] pad;
        logic             dollar;
        body_kind_t       kind;
        logic [7:0]       body_char;
    } job_t;

endpackage

// ===== hw/rtl/tslnf_emit.sv =====
module tslnf_emit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load_i,
    input  tslnf_pkg::job_t   job_i,
    output logic              ready_o,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_byte,
    output logic              m_last
);
    import tslnf_pkg::*;

    typedef enum logic [2:0] {
        PH_PAD,
        PH_DIGIT,
        PH_TAB,
        PH_DOLLAR,
        PH_BODY
    } phase_t;

    job_t             job_reg, job_next;
    logic             job_valid_reg, job_valid_next;
    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_byte_reg, m_byte_next;
    logic             m_last_reg, m_last_next;

    logic [CNT_W-1:0] phase_len;
    logic             phase_done;
    logic             final_step;
    logic             out_free;
    logic             step;
    phase_t           phase_after;
    phase_t           phase_start;
    logic [SIG_W-1:0] dig_idx;
    logic [3:0]       nib;
    logic [7:0]       byte_c;

    // length of the current phase
    always_comb begin
        case (phase_reg)
            PH_PAD:   phase_len = CNT_W'(job_reg.pad);
            PH_DIGIT: phase_len = CNT_W'(job_reg.sig);
            PH_BODY: begin
                case (job_reg.kind)
                    BODY_CARET: phase_len = CNT_W'(2);
                    BODY_META:  phase_len = CNT_W'(4);
                    default:    phase_len = CNT_W'(1);
                endcase
            end
            default:  phase_len = CNT_W'(1);
        endcase
    end

    assign phase_done = (cnt_reg + CNT_W'(1)) == phase_len;
    assign final_step = (phase_reg == PH_BODY) && phase_done;
    assign out_free   = !m_valid_reg || m_ready;
    assign step       = job_valid_reg && out_free;
    assign ready_o    = !job_valid_reg || (out_free && final_step);

    // phase order, skipping empty ones
    always_comb begin
        case (phase_reg)
            PH_PAD:   phase_after = PH_DIGIT;
            PH_DIGIT: phase_after = PH_TAB;
            PH_TAB:   phase_after = job_reg.dollar ? PH_DOLLAR : PH_BODY;
            default:  phase_after = PH_BODY;
        endcase
    end

    always_comb begin
        if (job_i.num_en) begin
            phase_start = (job_i.pad != '0) ? PH_PAD : PH_DIGIT;
        end else begin
            phase_start = job_i.dollar ? PH_DOLLAR : PH_BODY;
        end
    end

    // digit select, most significant first
    assign dig_idx = job_reg.sig - SIG_W'(1) - cnt_reg[SIG_W-1:0];

    always_comb begin
        nib = 4'h0;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (dig_idx == SIG_W'(i)) begin
                nib = job_reg.count[4*i +: 4];
            end
        end
    end

    // byte for the current position
    always_comb begin
        case (phase_reg)
            PH_PAD:    byte_c = CH_SPACE;
            PH_DIGIT:  byte_c = CH_ZERO + {4'b0000, nib};
            PH_TAB:    byte_c = CH_TAB;
            PH_DOLLAR: byte_c = CH_DOLLAR;
            PH_BODY: begin
                case (job_reg.kind)
                    BODY_CARET: byte_c = (cnt_reg == '0) ? CH_CARET : job_reg.body_char;
                    BODY_META: begin
                        case (cnt_reg[1:0])
                            2'd0:    byte_c = CH_UPPER_M;
                            2'd1:    byte_c = CH_DASH;
                            2'd2:    byte_c = CH_CARET;
                            default: byte_c = job_reg.body_char;
                        endcase
                    end
                    default:    byte_c = job_reg.body_char;
                endcase
            end
            default:   byte_c = job_reg.body_char;
        endcase
    end

    // sequencer and output register
    always_comb begin
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg;
        m_byte_next    = m_byte_reg;
        m_last_next    = m_last_reg;

        if (step) begin
            m_valid_next = 1'b1;
            m_byte_next  = byte_c;
            m_last_next  = final_step;
            if (phase_done) begin
                phase_next = phase_after;
                cnt_next   = '0;
            end else begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            if (final_step) begin
                job_valid_next = 1'b0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (load_i) begin
            job_next       = job_i;
            job_valid_next = 1'b1;
            phase_next     = phase_start;
            cnt_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            phase_reg     <= PH_BODY;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            m_valid_reg   <= m_valid_next;
            job_reg       <= job_next;
            m_byte_reg    <= m_byte_next;
            m_last_reg    <= m_last_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_last     = m_last_reg;

endmodule

// ===== hw/rtl/text_stream_line_number_filter.sv =====
// Line numbering text filter with cat-style display options.
// Input channel (s_valid/s_ready): one text byte per transfer, with
// s_start_of_file set on the first byte of a new file to restart the
// line count and the blank line tracking.
// Output channel (m_valid/m_ready): transformed bytes, m_last set on the
// final byte produced for each input byte. A squeezed blank line gives
// no output transfer at all.
// Configuration: cfg_wr_en writes bit 0 of cfg_wdata to the option at
// cfg_addr (0 number_all .. 5 show_nonprinting); other indexes are
// ignored. Write only while the block is idle.
// Path: input byte to the job register, then to the output register.
// Throughput: an input byte producing n output bytes holds the input
// until the sequencer sends its last byte; plain bytes flow at one per
// cycle unless m_ready stalls. Numbered lines add 7 bytes of prefix.
// Reset: options clear, line count zero, output empty, input ready.
// A stalled receiver holds the output register; the input keeps taking
// bytes until the pending job register is also occupied.
module text_stream_line_number_filter (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [tslnf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic                             cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_in_byte,
    input  logic                             s_start_of_file,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_out_byte,
    output logic                             m_last
);
    import tslnf_pkg::*;

    cfg_t             cfg_reg, cfg_next;
    logic             prev_nl_reg, prev_nl_next;
    logic             last_blank_reg, last_blank_next;
    logic [BCD_W-1:0] line_count_reg, line_count_next;

    logic             accept;
    logic             pwn;
    logic             lwb;
    logic [BCD_W-1:0] cnt_base;
    logic [BCD_W-1:0] cnt_inc;
    logic             carry;
    logic             is_nl;
    logic             squeeze;
    logic             numbering;
    logic [SIG_W-1:0] sig_c;
    logic [PAD_W-1:0] pad_c;
    job_t             job_c;
    logic             emit_ready;

    // configuration writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_NUMBER_ALL:       cfg_next.number_all       = cfg_wdata;
                REG_NUMBER_NONBLANK:  cfg_next.number_nonblank  = cfg_wdata;
                REG_SHOW_ENDS:        cfg_next.show_ends        = cfg_wdata;
                REG_SQUEEZE_BLANK:    cfg_next.squeeze_blank    = cfg_wdata;
                REG_SHOW_TABS:        cfg_next.show_tabs        = cfg_wdata;
                REG_SHOW_NONPRINTING: cfg_next.show_nonprinting = cfg_wdata;
                default: ;
            endcase
        end
    end

    assign accept = s_valid && s_ready;

    // line state as seen by this byte
    assign pwn      = s_start_of_file ? 1'b1 : prev_nl_reg;
    assign lwb      = s_start_of_file ? 1'b0 : last_blank_reg;
    assign cnt_base = s_start_of_file ? '0 : line_count_reg;
    assign is_nl    = (s_in_byte == CH_NL);

    assign squeeze   = cfg_reg.squeeze_blank && pwn && is_nl && lwb;
    assign numbering = pwn && ((cfg_reg.number_all && !cfg_reg.number_nonblank) ||
                               (cfg_reg.number_nonblank && !is_nl));

    // bcd increment with saturation
    always_comb begin
        cnt_inc = cnt_base;
        carry   = 1'b1;
        if (cnt_base >= BCD_MAX) begin
            cnt_inc = BCD_MAX;
        end else begin
            for (int i = 0; i < BCD_DIGITS; i++) begin
                if (carry) begin
                    if (cnt_base[4*i +: 4] == 4'h9) begin
                        cnt_inc[4*i +: 4] = 4'h0;
                    end else begin
                        cnt_inc[4*i +: 4] = cnt_base[4*i +: 4] + 4'h1;
                        carry = 1'b0;
                    end
                end
            end
        end
    end

    // significant digits and left padding of the new count
    always_comb begin
        sig_c = SIG_W'(1);
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (cnt_inc[4*i +: 4] != 4'h0) begin
                sig_c = SIG_W'(i + 1);
            end
        end
        if (NUMBER_DIGITS > int'(sig_c)) begin
            pad_c = PAD_W'(NUMBER_DIGITS - int'(sig_c));
        end else begin
            pad_c = '0;
        end
    end

    // job for the emitter
    always_comb begin
        job_c.num_en = numbering;
        job_c.count  = cnt_inc;
        job_c.sig    = sig_c;
        job_c.pad    = pad_c;
        job_c.dollar = cfg_reg.show_ends && is_nl;
        if (cfg_reg.show_tabs && s_in_byte == CH_TAB) begin
            job_c.kind      = BODY_CARET;
            job_c.body_char = CH_UPPER_I;
        end else if (cfg_reg.show_nonprinting && s_in_byte < CH_CTRL_END && !is_nl &&
                     s_in_byte != CH_TAB) begin
            job_c.kind      = BODY_CARET;
            job_c.body_char = s_in_byte + CARET_OFFSET;
        end else if (cfg_reg.show_nonprinting && s_in_byte == CH_DEL) begin
            job_c.kind      = BODY_CARET;
            job_c.body_char = CH_QUEST;
        end else if (cfg_reg.show_nonprinting && s_in_byte >= CH_META_LO &&
                     s_in_byte <= CH_META_HI) begin
            job_c.kind      = BODY_META;
            job_c.body_char = s_in_byte - CARET_OFFSET;
        end else begin
            job_c.kind      = BODY_PLAIN;
            job_c.body_char = s_in_byte;
        end
    end

    // line state update on each input transfer
    always_comb begin
        prev_nl_next    = prev_nl_reg;
        last_blank_next = last_blank_reg;
        line_count_next = line_count_reg;
        if (accept) begin
            if (squeeze) begin
                prev_nl_next    = 1'b1;
                last_blank_next = lwb;
                line_count_next = cnt_base;
            end else begin
                prev_nl_next    = is_nl;
                last_blank_next = pwn && is_nl;
                line_count_next = numbering ? cnt_inc : cnt_base;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg        <= '0;
            prev_nl_reg    <= 1'b1;
            last_blank_reg <= 1'b0;
            line_count_reg <= '0;
        end else begin
            cfg_reg        <= cfg_next;
            prev_nl_reg    <= prev_nl_next;
            last_blank_reg <= last_blank_next;
            line_count_reg <= line_count_next;
        end
    end

    assign s_ready = emit_ready;

    tslnf_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_i     (accept && !squeeze),
        .job_i      (job_c),
        .ready_o    (emit_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

endmodule

// ===== hw/rtl/tslnf_checker.sv =====
`include "text_stream_line_number_filter_macros.svh"

module tslnf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_last
);

    // a stalled output byte holds
    `TSLNF_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last), "output changed while stalled")

    // an expansion keeps streaming: after a non-last transfer the next byte is ready
    `TSLNF_ASSERT(a_no_gap, aclk, aresetn, m_valid && m_ready && !m_last |=> m_valid, "gap inside an expanded item")

    // a stalled non-last byte means more bytes are pending, so input is held
    `TSLNF_ASSERT(a_stall_blocks, aclk, aresetn, m_valid && !m_last && !m_ready |-> !s_ready, "input taken while item output is stalled")

    // reset empties the output and opens the input
    `TSLNF_ASSERT_ALWAYS(a_reset_state, aclk, !aresetn |=> !m_valid && s_ready, "bad state after reset")

endmodule

bind text_stream_line_number_filter tslnf_checker u_tslnf_checker (.*);
